@@ design/assert_macros.svh @@
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ design/rkst_pkg.sv @@
// ----------------------------------------------------------------------------
// rkst_pkg
// types, codes and defaults for the refcounted keyed slot table
// ----------------------------------------------------------------------------
`default_nettype none

package rkst_pkg;

    localparam int ENTRIES_DEF       = 64;
    localparam int PAYLOAD_WIDTH_DEF = 64;
    localparam int KEY_WIDTH_DEF     = 32;
    localparam int COUNT_WIDTH_DEF   = 16;

    // fixed field widths of the stream items
    localparam int CMD_W      = 2;
    localparam int KEY_FW     = 32;
    localparam int PAYLOAD_FW = 64;
    localparam int IDX_FW     = 6;
    localparam int COUNT_FW   = 16;
    localparam int OCC_FW     = 7;
    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 104;

    typedef enum logic [CMD_W-1:0] {
        CMD_ACQUIRE    = 2'd0,
        CMD_RELEASE    = 2'd1,
        CMD_REPLACE    = 2'd2,
        CMD_INVALIDATE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_UPD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                  status;
        logic [IDX_FW-1:0]     slot_index;
        logic                  hit;
        logic                  created;
        logic                  deleted;
        logic                  found;
        logic [COUNT_FW-1:0]   ref_count;
        logic                  stale_mark;
        logic [PAYLOAD_FW-1:0] payload_out;
        logic [OCC_FW-1:0]     occupancy;
    } result_t;

endpackage

`default_nettype wire

@@ design/rkst_cam.sv @@
// ----------------------------------------------------------------------------
// rkst_cam
// key and used-bit array with parallel compare and free-slot search
// ----------------------------------------------------------------------------
`default_nettype none

module rkst_cam #(
    parameter int ENTRIES   = 64,
    parameter int KEY_WIDTH = 32,
    parameter int IW        = $clog2(ENTRIES)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [KEY_WIDTH-1:0] lookup_key,
    output logic                      match_ok,
    output logic [IW-1:0]             match_idx,
    output logic                      free_ok,
    output logic [IW-1:0]             free_idx,
    input  wire logic                 wr_en,
    input  wire logic [IW-1:0]        wr_idx,
    input  wire logic                 wr_used,
    input  wire logic [KEY_WIDTH-1:0] wr_key
);

    logic [KEY_WIDTH-1:0] key_reg [ENTRIES];
    logic [ENTRIES-1:0]   used_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else if (wr_en)
        begin
            used_reg[wr_idx] <= wr_used;
        end
    end

    // keys need no reset, used bits gate them
    always_ff @(posedge clk)
    begin
        if (wr_en && wr_used)
        begin
            key_reg[wr_idx] <= wr_key;
        end
    end

    // lowest matching and lowest free slot
    always_comb
    begin
        match_ok  = 1'b0;
        match_idx = '0;
        free_ok   = 1'b0;
        free_idx  = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (used_reg[i] && (key_reg[i] == lookup_key))
            begin
                match_ok  = 1'b1;
                match_idx = IW'(i);
            end
            if (!used_reg[i])
            begin
                free_ok  = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

endmodule

`default_nettype wire

@@ design/rkst_slot_mem.sv @@
// ----------------------------------------------------------------------------
// rkst_slot_mem
// synchronous slot memory holding count, stale mark and payload
// ----------------------------------------------------------------------------
`default_nettype none

module rkst_slot_mem #(
    parameter int ENTRIES = 64,
    parameter int WIDTH   = 81,
    parameter int IW      = $clog2(ENTRIES)
) (
    input  wire logic             clk,
    input  wire logic             rd_en,
    input  wire logic [IW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data,
    input  wire logic             wr_en,
    input  wire logic [IW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ design/refcounted_keyed_slot_table.sv @@
// ----------------------------------------------------------------------------
// refcounted_keyed_slot_table
// keyed table of reference-counted slots with acquire, release, replace and
// invalidate commands
// ----------------------------------------------------------------------------
// usage:
//   in channel (in_tvalid/in_tready): one command beat, tuser holds the
//   command, tdata holds key, release_key and payload.
//   out channel (out_tvalid/out_tready): one result beat per command, tuser
//   holds status, tdata the remaining result fields.
//   one command at a time: a beat is taken, then a lookup step (parallel
//   key compare over all slots, slot memory read issued) and an update
//   step (read-modify-write of the slot memory). acquire, release and
//   invalidate then give their result; replace runs the lookup and update
//   pair twice before its result is given.
//   the result stays in its output register while out_tready is low and
//   no new command is taken until it is delivered.
//   reset clears all used bits and the occupancy count at once; the block
//   is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module refcounted_keyed_slot_table #(
    parameter int ENTRIES       = rkst_pkg::ENTRIES_DEF,
    parameter int PAYLOAD_WIDTH = rkst_pkg::PAYLOAD_WIDTH_DEF,
    parameter int KEY_WIDTH     = rkst_pkg::KEY_WIDTH_DEF,
    parameter int COUNT_WIDTH   = rkst_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_tvalid,
    output logic                                 in_tready,
    // key [31:0], release_key [63:32], payload [127:64]
    input  wire logic [rkst_pkg::IN_DATA_W-1:0]  in_tdata,
    // command [1:0]
    input  wire logic [rkst_pkg::CMD_W-1:0]      in_tuser,
    output logic                                 out_tvalid,
    input  wire logic                            out_tready,
    // slot_index [5:0], hit [6], created [7], deleted [8], found [9],
    // ref_count [25:10], stale_mark [26], payload_out [90:27],
    // occupancy [97:91], zero [103:98]
    output logic [rkst_pkg::OUT_DATA_W-1:0]      out_tdata,
    // status [0]
    output logic                                 out_tuser
);

    import rkst_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam int OW = $clog2(ENTRIES + 1);
    localparam int MW = COUNT_WIDTH + 1 + PAYLOAD_WIDTH;

    state_t               state_reg, state_next;
    cmd_t                 cmd_reg;
    logic [KEY_WIDTH-1:0] key_reg, rkey_reg;
    logic [PAYLOAD_WIDTH-1:0] pl_reg;
    logic                 rel_phase_reg, rel_phase_next;
    logic                 sv_found_reg, sv_found_next;
    logic                 sv_del_reg, sv_del_next;
    logic [OW-1:0]        total_reg, total_next;
    result_t              res_reg, res_next;

    logic                 lk_match_reg, lk_free_reg;
    logic [IW-1:0]        lk_midx_reg, lk_fidx_reg;

    logic [KEY_WIDTH-1:0] lookup_key;
    logic                 match_ok, free_ok;
    logic [IW-1:0]        match_idx, free_idx;
    logic                 cam_wr_en, cam_wr_used;
    logic [IW-1:0]        cam_wr_idx;

    logic                 mem_rd_en, mem_wr_en;
    logic [MW-1:0]        mem_rd_data, mem_wr_data;
    logic [IW-1:0]        mem_wr_addr;

    logic [63:0]          key_wide, rkey_wide, pl_wide;
    logic [COUNT_WIDTH-1:0] cur_cnt, new_cnt;
    logic                 cur_stale;
    logic [PAYLOAD_WIDTH-1:0] cur_pl;
    logic                 do_acq;

    assign key_wide  = {32'b0, in_tdata[31:0]};
    assign rkey_wide = {32'b0, in_tdata[63:32]};
    assign pl_wide   = in_tdata[127:64];

    assign lookup_key = rel_phase_reg ? rkey_reg : key_reg;

    rkst_cam #(
        .ENTRIES   (ENTRIES),
        .KEY_WIDTH (KEY_WIDTH),
        .IW        (IW)
    ) u_cam (
        .clk        (clk),
        .rst_n      (rst_n),
        .lookup_key (lookup_key),
        .match_ok   (match_ok),
        .match_idx  (match_idx),
        .free_ok    (free_ok),
        .free_idx   (free_idx),
        .wr_en      (cam_wr_en),
        .wr_idx     (cam_wr_idx),
        .wr_used    (cam_wr_used),
        .wr_key     (key_reg)
    );

    assign mem_rd_en = (state_reg == ST_LOOK);

    rkst_slot_mem #(
        .ENTRIES (ENTRIES),
        .WIDTH   (MW),
        .IW      (IW)
    ) u_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (match_idx),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    assign cur_pl    = mem_rd_data[PAYLOAD_WIDTH-1:0];
    assign cur_stale = mem_rd_data[PAYLOAD_WIDTH];
    assign cur_cnt   = mem_rd_data[MW-1:PAYLOAD_WIDTH+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rel_phase_reg <= 1'b0;
            total_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rel_phase_reg <= rel_phase_next;
            total_reg     <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_tvalid && in_tready)
        begin
            cmd_reg  <= cmd_t'(in_tuser);
            key_reg  <= key_wide[KEY_WIDTH-1:0];
            rkey_reg <= rkey_wide[KEY_WIDTH-1:0];
            pl_reg   <= pl_wide[PAYLOAD_WIDTH-1:0];
        end
        if (state_reg == ST_LOOK)
        begin
            lk_match_reg <= match_ok;
            lk_midx_reg  <= match_idx;
            lk_free_reg  <= free_ok;
            lk_fidx_reg  <= free_idx;
        end
        sv_found_reg <= sv_found_next;
        sv_del_reg   <= sv_del_next;
        res_reg      <= res_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        rel_phase_next = rel_phase_reg;
        sv_found_next  = sv_found_reg;
        sv_del_next    = sv_del_reg;
        total_next     = total_reg;
        res_next       = res_reg;
        cam_wr_en      = 1'b0;
        cam_wr_used    = 1'b0;
        cam_wr_idx     = lk_midx_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = lk_midx_reg;
        mem_wr_data    = mem_rd_data;
        new_cnt        = cur_cnt;
        do_acq         = 1'b0;
        in_tready      = 1'b0;
        out_tvalid     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_tready = 1'b1;
                if (in_tvalid)
                begin
                    state_next     = ST_LOOK;
                    rel_phase_next = (cmd_t'(in_tuser) == CMD_REPLACE);
                    sv_found_next  = 1'b0;
                    sv_del_next    = 1'b0;
                end
            end
            ST_LOOK:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                res_next = '0;
                if (rel_phase_reg || cmd_reg == CMD_RELEASE)
                begin
                    if (lk_match_reg)
                    begin
                        res_next.found      = 1'b1;
                        res_next.slot_index = IDX_FW'(64'(lk_midx_reg));
                        res_next.stale_mark = cur_stale;
                        if (cur_cnt <= COUNT_WIDTH'(1))
                        begin
                            cam_wr_en        = 1'b1;
                            cam_wr_used      = 1'b0;
                            res_next.deleted = 1'b1;
                            if (total_reg != '0)
                            begin
                                total_next = total_reg - OW'(1);
                            end
                        end
                        else
                        begin
                            new_cnt            = cur_cnt - COUNT_WIDTH'(1);
                            mem_wr_en          = 1'b1;
                            mem_wr_data        = {new_cnt, cur_stale, cur_pl};
                            res_next.ref_count = COUNT_FW'(64'(new_cnt));
                        end
                    end
                end
                else if (cmd_reg == CMD_INVALIDATE)
                begin
                    if (lk_match_reg)
                    begin
                        mem_wr_en           = 1'b1;
                        mem_wr_data         = {cur_cnt, 1'b1, cur_pl};
                        res_next.found      = 1'b1;
                        res_next.slot_index = IDX_FW'(64'(lk_midx_reg));
                        res_next.ref_count  = COUNT_FW'(64'(cur_cnt));
                        res_next.stale_mark = 1'b1;
                    end
                end
                else
                begin
                    do_acq = 1'b1;
                    if (lk_match_reg)
                    begin
                        if (cur_cnt != {COUNT_WIDTH{1'b1}})
                        begin
                            new_cnt = cur_cnt + COUNT_WIDTH'(1);
                        end
                        mem_wr_en            = 1'b1;
                        mem_wr_data          = {new_cnt, cur_stale, cur_pl};
                        res_next.hit         = 1'b1;
                        res_next.slot_index  = IDX_FW'(64'(lk_midx_reg));
                        res_next.ref_count   = COUNT_FW'(64'(new_cnt));
                        res_next.stale_mark  = cur_stale;
                        res_next.payload_out = PAYLOAD_FW'(64'(cur_pl));
                    end
                    else if (lk_free_reg)
                    begin
                        cam_wr_en            = 1'b1;
                        cam_wr_used          = 1'b1;
                        cam_wr_idx           = lk_fidx_reg;
                        mem_wr_en            = 1'b1;
                        mem_wr_addr          = lk_fidx_reg;
                        mem_wr_data          = {COUNT_WIDTH'(1), 1'b0, pl_reg};
                        total_next           = total_reg + OW'(1);
                        res_next.created     = 1'b1;
                        res_next.slot_index  = IDX_FW'(64'(lk_fidx_reg));
                        res_next.ref_count   = COUNT_FW'(1);
                        res_next.payload_out = PAYLOAD_FW'(64'(pl_reg));
                    end
                    else
                    begin
                        res_next.status = 1'b1;
                    end
                end

                if (rel_phase_reg)
                begin
                    // release half of a replace, acquire follows
                    sv_found_next  = res_next.found;
                    sv_del_next    = res_next.deleted;
                    rel_phase_next = 1'b0;
                    res_next       = res_reg;
                    state_next     = ST_LOOK;
                end
                else
                begin
                    if (do_acq && cmd_reg == CMD_REPLACE)
                    begin
                        res_next.found   = sv_found_reg;
                        res_next.deleted = sv_del_reg;
                    end
                    res_next.occupancy = OCC_FW'(64'(total_next));
                    state_next         = ST_OUT;
                end
            end
            ST_OUT:
            begin
                out_tvalid = 1'b1;
                if (out_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_tuser = res_reg.status;
    assign out_tdata = {6'b0,
                        res_reg.occupancy,
                        res_reg.payload_out,
                        res_reg.stale_mark,
                        res_reg.ref_count,
                        res_reg.found,
                        res_reg.deleted,
                        res_reg.created,
                        res_reg.hit,
                        res_reg.slot_index};

endmodule

`default_nettype wire

@@ design/rkst_checker.sv @@
// ----------------------------------------------------------------------------
// rkst_checker
// port-level checks for the refcounted keyed slot table
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rkst_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           in_tvalid,
    input wire logic                           in_tready,
    input wire logic                           out_tvalid,
    input wire logic                           out_tready,
    input wire logic [rkst_pkg::OUT_DATA_W-1:0] out_tdata,
    input wire logic                           out_tuser
);

    // held result beat stays offered
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)

    // a taken command never gets its result in the next cycle
    `ASSERT_NEXT(a_no_early, clk, rst_n, in_tvalid && in_tready, !out_tvalid)

    // one command in flight: no input beat while a result waits
    `ASSERT_IMPL(a_one_flight, clk, rst_n, out_tvalid, !in_tready)

    // full status and creation exclude each other
    `ASSERT_IMPL(a_full_no_create, clk, rst_n, out_tvalid && out_tuser, !out_tdata[7])

    // a slot is either hit or created, not both
    `ASSERT_IMPL(a_hit_xor_create, clk, rst_n, out_tvalid, !(out_tdata[6] && out_tdata[7]))

endmodule

bind refcounted_keyed_slot_table rkst_checker u_rkst_checker (.*);

`default_nettype wire
